### rtl/core/opha_pkg.sv
// Shared types and constants for the object pool handle allocator.
// Holds request codes, result status codes and the free-list control structs.
// No dependencies.
`default_nettype none

package opha_pkg;

  // Width of the handle fields on the request and result buses.
  localparam int unsigned HANDLE_W = 6;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // Request commands. The fourth code is unused and is answered as a no-op.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRY     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK            = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY         = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_ALLOCATED = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EXHAUSTED     = 2'd3;

  // Free-list control from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic pop;
    logic push;
  } fifo_ctl_t;

  // Free-list status back to the sequencer.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

`default_nettype wire

### rtl/core/opha_map_ram.sv
// Allocated-bit map of the handle pool: one bit per handle in a synchronous RAM.
// The read data is registered. Depends on nothing but its parameters.
`default_nettype none

module opha_map_ram #(
  parameter int unsigned POOL_SIZE = 64,
  localparam int unsigned HW = $clog2(POOL_SIZE)
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [HW-1:0] rd_addr,
  output logic               rd_data,
  input  wire logic          wr_en,
  input  wire logic [HW-1:0] wr_addr,
  input  wire logic          wr_data
);

  logic mem [POOL_SIZE];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/opha_free_fifo.sv
// Circular FIFO free list of released handles, kept in a synchronous RAM.
// Head entry is read into a register ahead of the pop. Depends on opha_pkg.
`default_nettype none

module opha_free_fifo
  import opha_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64,
  localparam int unsigned HW = $clog2(POOL_SIZE),
  localparam int unsigned CW = $clog2(POOL_SIZE + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fifo_ctl_t     ctl,
  input  wire logic [HW-1:0] wr_data,
  output logic      [HW-1:0] rd_data,
  output fifo_sts_t          sts
);

  localparam logic [HW-1:0] LAST_IDX = HW'(POOL_SIZE - 1);

  logic [HW-1:0] mem [POOL_SIZE];
  logic [HW-1:0] rd_data_r;
  logic [HW-1:0] head_r, head_nxt;
  logic [HW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (ctl.push) begin
      tail_nxt  = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign rd_data   = rd_data_r;
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(POOL_SIZE));

`ifndef ASSERT_OFF
  // Requests are handled one at a time, so a pop and a push never coincide.
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("free list pushed and popped in the same cycle");

  // The list never holds more handles than the pool has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(POOL_SIZE))
    else $error("free list count beyond pool size");

  // No pop from an empty list and no push into a full one.
  a_no_under_over: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.pop && sts.empty) && !(ctl.push && sts.full))
    else $error("free list underflow or overflow");
`endif

endmodule

`default_nettype wire

### rtl/core/object_pool_handle_allocator_top.sv
// Top level of the object pool handle allocator: request sequencer and result register.
// Depends on opha_pkg, opha_map_ram and opha_free_fifo.
`default_nettype none

// The allocator hands out numbered handles from a pool of POOL_SIZE entries and
// answers every request with exactly one result. Allocate returns the oldest
// released handle from a FIFO free list, or a never-used handle counting up from
// zero while the list is empty; once all POOL_SIZE handles exist and the list is
// empty it reports exhaustion. Try-allocate takes from the free list only and
// reports an empty list otherwise. Release checks the allocated-bit map, rejects a
// handle that is not allocated, and otherwise clears its bit and appends it to the
// free list. A request passes two states: ST_IDLE reads the allocated-bit map and
// the free-list head from their synchronous RAMs, ST_EXEC decides, writes both back
// and loads the result register. A new request is taken while an earlier result
// still waits in the output register. The map needs no clearing pass after reset:
// bits at or above the count of created handles read as clear, since every handle
// below that count was written when it was first handed out.
module object_pool_handle_allocator_top
  import opha_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Request channel.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [1:0] command, [7:2] handle_in
  // Result channel.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata   // [5:0] handle_out, [7:6] status
);

  localparam int unsigned HW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);
  // Wide enough to compare an incoming handle against the pool size.
  localparam int unsigned XW = ((HW > HANDLE_W) ? HW : HANDLE_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Captured request.
  logic [CMD_W-1:0] cmd_r;
  logic [HW-1:0]    hin_idx_r;
  logic             hin_ok_r;

  // Count of handles handed out fresh so far; doubles as the map fill count.
  logic [CW-1:0] created_r, created_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Request fields and their decode.
  logic [CMD_W-1:0]    in_cmd;
  logic [HANDLE_W-1:0] in_handle;
  logic [XW-1:0]       hin_x;
  logic [HW-1:0]       hin_idx;
  logic                in_fire;

  // Memory interfaces.
  fifo_ctl_t     fifo_ctl;
  fifo_sts_t     fifo_sts;
  logic [HW-1:0] fifo_rd_data;
  logic          map_rd_data;
  logic          map_wr_en;
  logic [HW-1:0] map_wr_addr;
  logic          map_wr_data;

  // Decision stage.
  logic          out_free;
  logic          exec_fire;
  logic          map_bit;
  logic [HW-1:0] hout;

  assign in_cmd    = in_tdata[1:0];
  assign in_handle = in_tdata[7:2];
  assign hin_x     = XW'(in_handle);
  assign hin_idx   = HW'(hin_x);

  // The block takes a request whenever it is not busy deciding the previous one.
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // The decision may only retire when the result register can take it.
  assign out_free  = !out_valid_r || out_tready;
  assign exec_fire = (state_r == ST_EXEC) && out_free;

  // A map bit beyond the created count was never written and reads as clear.
  assign map_bit = map_rd_data && (CW'(hin_idx_r) < created_r);

  always_comb begin
    state_nxt       = state_r;
    created_nxt     = created_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_handle_nxt  = out_handle_r;
    out_status_nxt  = out_status_r;
    fifo_ctl.rd_en  = in_fire;
    fifo_ctl.pop    = 1'b0;
    fifo_ctl.push   = 1'b0;
    map_wr_en       = 1'b0;
    map_wr_addr     = hin_idx_r;
    map_wr_data     = 1'b0;
    hout            = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_OK;
          if (cmd_r == CMD_ALLOC || cmd_r == CMD_TRY) begin
            priority if (!fifo_sts.empty) begin
              // Oldest released handle goes out first.
              hout          = fifo_rd_data;
              fifo_ctl.pop  = 1'b1;
              map_wr_en     = 1'b1;
              map_wr_addr   = fifo_rd_data;
              map_wr_data   = 1'b1;
            end else if (cmd_r == CMD_TRY) begin
              out_status_nxt = STS_EMPTY;
            end else if (created_r < CW'(POOL_SIZE)) begin
              // Fresh handle; writing its map bit extends the valid region.
              hout        = HW'(created_r);
              map_wr_en   = 1'b1;
              map_wr_addr = HW'(created_r);
              map_wr_data = 1'b1;
              created_nxt = created_r + 1'b1;
            end else begin
              out_status_nxt = STS_EXHAUSTED;
            end
          end else if (cmd_r == CMD_RELEASE) begin
            if (hin_ok_r && map_bit && !fifo_sts.full) begin
              map_wr_en     = 1'b1;
              map_wr_addr   = hin_idx_r;
              map_wr_data   = 1'b0;
              fifo_ctl.push = 1'b1;
            end else begin
              out_status_nxt = STS_NOT_ALLOCATED;
            end
          end
          out_handle_nxt = HANDLE_W'(hout);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      created_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      created_r   <= created_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_cmd;
      hin_idx_r <= hin_idx;
      hin_ok_r  <= (hin_x < XW'(POOL_SIZE));
    end
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  opha_map_ram #(
    .POOL_SIZE (POOL_SIZE)
  ) u_map (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (hin_idx),
    .rd_data (map_rd_data),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  opha_free_fifo #(
    .POOL_SIZE (POOL_SIZE)
  ) u_free (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .wr_data (hin_idx_r),
    .rd_data (fifo_rd_data),
    .sts     (fifo_sts)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_status_r, out_handle_r};

`ifndef ASSERT_OFF
  // An accepted request always moves the sequencer to the decision cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted request did not reach the decision cycle");

  // A new result appears only after a decision cycle.
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_EXEC))
    else $error("result raised without a decision cycle");

  // Exhaustion is reported only when every handle has been created.
  a_exhausted_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status_r == STS_EXHAUSTED) |-> (created_r == CW'(POOL_SIZE)))
    else $error("exhaustion reported with handles left to create");
`endif

endmodule

`default_nettype wire
